/* rtl/lruwo_pkg.sv */
// Shared types and field widths for the true-LRU way order block.
`default_nettype none

package lruwo_pkg;

    localparam int KIND_W   = 2;
    localparam int SET_W    = 6;
    localparam int WAY_W    = 2;
    localparam int VICTIM_W = 2;

    // Width used to compare way numbers of any supported width (up to 16 ways).
    localparam int WAYCMP_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_TOUCH      = 2'd0,
        KIND_INVALIDATE = 2'd1,
        KIND_QUERY      = 2'd2
    } t_kind;

    typedef struct packed {
        logic touch;
        logic inval;
    } t_upd_ctrl;

endpackage

`default_nettype wire

/* rtl/lru_way_order_per_set.sv */
// Top level of the true-LRU way order block with its per-set order memory.
`default_nettype none

// True-LRU replacement state for a set-associative cache. Each set keeps the
// order of its ways from least to most recently used in one memory row. A
// touch request moves the way to the most recent end, an invalidate request
// moves it to the least recent end, and a query (or the unused kind code)
// leaves the order alone. Every request returns the victim way, the front of
// the set's order after the step; a set index at or beyond SETS returns way
// zero and changes nothing, and a way number at or beyond WAYS changes
// nothing. After reset the block writes the identity order into every row
// and holds o_in_stall high meanwhile. From then on it takes one request per
// cycle while the result is not stalled: the row is read on acceptance, then
// modified and written back as stage one advances, and a request to the set
// just written picks up the new row from a bypass register instead of the
// memory. The result sits in an output register, so a stalled result holds
// back at most one further request.
module lru_way_order_per_set
    import lruwo_pkg::*;
#(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [SET_W-1:0]    i_set_index,
    input  wire logic [WAY_W-1:0]    i_way,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [VICTIM_W-1:0] o_victim_way
);

    localparam int WBITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SBITS   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W   = WAYS * WBITS;
    localparam int SETX_W  = 16;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    t_state r_state;
    logic [SBITS-1:0] r_clr_idx;

    // Order memory: one row per set, way numbers packed from front to back.
    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] r_rd_row;

    // Bypass for a request that reads the set being written in the same cycle.
    logic             r_fwd;
    logic [ROW_W-1:0] r_fwd_row;

    // Stage one: the accepted request waiting for its row.
    logic               r_s1_valid;
    logic [KIND_W-1:0]  r_s1_kind;
    logic [SBITS-1:0]   r_s1_addr;
    logic               r_s1_inrange;
    logic [WAY_W-1:0]   r_s1_way;

    logic                r_out_valid;
    logic [VICTIM_W-1:0] r_out_victim;

    logic [WAYS-1:0][WBITS-1:0] id_row;
    logic [WAYS-1:0][WBITS-1:0] cur_row;
    logic [WAYS-1:0][WBITS-1:0] new_row;
    logic [SETX_W-1:0]          in_set_ext;
    logic [SBITS-1:0]           in_addr;
    logic                       in_inrange;
    logic                       s1_adv;
    logic                       in_acc;
    logic                       s1_wr;
    logic                       mem_we;
    logic [SBITS-1:0]           mem_wa;
    logic [ROW_W-1:0]           mem_wd;
    logic [VICTIM_W-1:0]        victim;
    t_upd_ctrl                  upd_ctrl;

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            id_row[i] = WBITS'(i);
        end
    end

    assign in_set_ext = SETX_W'(i_set_index);
    assign in_addr    = in_set_ext[SBITS-1:0];
    assign in_inrange = (32'(in_set_ext) < 32'(SETS));

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_CLEAR) || (r_s1_valid && !s1_adv);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign s1_wr      = r_s1_valid && s1_adv && r_s1_inrange;

    assign cur_row = r_fwd ? r_fwd_row : r_rd_row;

    always_comb begin
        upd_ctrl = '0;
        unique case (r_s1_kind)
            KIND_TOUCH:      upd_ctrl.touch = 1'b1;
            KIND_INVALIDATE: upd_ctrl.inval = 1'b1;
            default:         upd_ctrl       = '0;
        endcase
    end

    lruwo_row_update #(
        .WAYS  (WAYS),
        .WBITS (WBITS)
    ) u_row_update (
        .i_row  (cur_row),
        .i_ctrl (upd_ctrl),
        .i_way  (r_s1_way),
        .o_row  (new_row)
    );

    always_comb begin
        logic [WAYCMP_W-1:0] front_ext;
        front_ext = WAYCMP_W'(new_row[0]);
        victim    = r_s1_inrange ? front_ext[VICTIM_W-1:0] : '0;
    end

    // The single write port serves the clearing pass and the write-back.
    assign mem_we = (r_state == ST_CLEAR) || s1_wr;
    assign mem_wa = (r_state == ST_CLEAR) ? r_clr_idx : r_s1_addr;
    assign mem_wd = (r_state == ST_CLEAR) ? ROW_W'(id_row) : ROW_W'(new_row);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (in_acc) begin
            r_rd_row <= mem[in_addr];
        end
    end

    // Payload registers of stage one and the bypass row.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind    <= i_kind;
            r_s1_addr    <= in_addr;
            r_s1_inrange <= in_inrange;
            r_s1_way     <= i_way;
            r_fwd_row    <= ROW_W'(new_row);
        end
    end

    // Control state, the clearing pass and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_idx    <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fwd        <= 1'b0;
            r_out_victim <= '0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr_idx == SBITS'(SETS - 1)) begin
                        r_state <= ST_RUN;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                ST_RUN: begin
                    r_state <= ST_RUN;
                end
                default: begin
                    r_state <= ST_CLEAR;
                end
            endcase

            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_wr && (r_s1_addr == in_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (r_s1_valid && s1_adv) begin
                r_out_valid  <= 1'b1;
                r_out_victim <= victim;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_out_victim;

endmodule

`default_nettype wire

/* rtl/lruwo_row_update.sv */
// Reorders one set's way permutation for a touch or an invalidate request.
`default_nettype none

module lruwo_row_update
    import lruwo_pkg::*;
#(
    parameter int WAYS  = 4,
    parameter int WBITS = 2
) (
    input  wire logic [WAYS-1:0][WBITS-1:0] i_row,
    input  wire t_upd_ctrl                  i_ctrl,
    input  wire logic [WAY_W-1:0]           i_way,
    output logic      [WAYS-1:0][WBITS-1:0] o_row
);

    logic [WAYCMP_W-1:0] way_ext;
    logic [WBITS-1:0]    way_val;
    logic                way_ok;
    logic [WAYS-1:0]     hit;
    logic [WAYS-1:0]     at_or_after;
    logic [WAYS-1:0]     strictly_after;
    logic                found;
    logic                seen;

    assign way_ext = WAYCMP_W'(i_way);
    assign way_val = way_ext[WBITS-1:0];
    assign way_ok  = (way_ext < WAYCMP_W'(WAYS));

    // Locate the requested way and mark the positions from its slot onwards.
    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
            hit[i]            = way_ok && (WAYCMP_W'(i_row[i]) == way_ext);
            strictly_after[i] = seen;
            seen              = seen | hit[i];
            at_or_after[i]    = seen;
        end
        found = seen;
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            o_row[i] = i_row[i];
            if (found && i_ctrl.touch && at_or_after[i]) begin
                o_row[i] = (i == WAYS - 1) ? way_val : i_row[(i + 1) % WAYS];
            end else if (found && i_ctrl.inval && !strictly_after[i]) begin
                o_row[i] = (i == 0) ? way_val : i_row[(i + WAYS - 1) % WAYS];
            end
        end
    end

endmodule

`default_nettype wire

/* tb/sv/lru_way_order_per_set_tb.sv */
// Self-checking testbench for the per-set true-LRU way order block.
`timescale 1ns / 1ps

module lru_way_order_per_set_tb;

    import lruwo_pkg::*;

    localparam int LRU_WAYS = 4;
    localparam int LRU_SETS = 64;

    // The fourth kind code has no package name; the block treats it as a query.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    // Cycles without any handshake before the run is declared hung. The
    // slowest legitimate quiet spell is the clearing pass after reset or the
    // long receiver hold-off, both well under this limit.
    localparam int WATCHDOG_LIMIT = 2000;

    // Long receiver hold-off, in cycles, and the result counts that trigger it.
    localparam int LONG_HOLD     = 60;
    localparam int HOLD_AT_FIRST = 100;
    localparam int HOLD_AT_LATER = 450;

    localparam int RANDOM_REQUESTS = 600;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way;
        bit                drain;
    } t_lru_request;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind;
    logic [SET_W-1:0]    i_set_index;
    logic [WAY_W-1:0]    i_way;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [VICTIM_W-1:0] o_victim_way;

    lru_way_order_per_set #(
        .WAYS(LRU_WAYS),
        .SETS(LRU_SETS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_set_index  (i_set_index),
        .i_way        (i_way),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_victim_way (o_victim_way)
    );

    // Our own copy of the replacement order: entry 0 of each row is the
    // least recently used way, the last entry the most recently used.
    logic [WAY_W-1:0]    lru_order [LRU_SETS][LRU_WAYS];

    t_lru_request        request_queue [$];
    logic [VICTIM_W-1:0] victim_expect [$];

    t_lru_request        next_request;
    logic [VICTIM_W-1:0] victim_next;
    logic [VICTIM_W-1:0] victim_want;
    int                  mismatch_count = 0;
    int                  issued_count   = 0;
    int                  result_count   = 0;
    int                  send_gap       = 0;
    int                  recv_hold      = 0;
    bit                  send_burst     = 1'b1;
    bit                  recv_burst     = 1'b1;
    int                  idle_cycles    = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Applies one request to the predicted order and returns the new victim.
    // A touch rotates the way to the back of the row and an invalidate to the
    // front; the ways in between slide one place to close the gap. A query,
    // the spare kind code, or a way that is already at its target end leaves
    // the row as it is. With six set bits and 64 sets every index is in range.
    task automatic lru_apply(input logic [KIND_W-1:0] kind,
                             input logic [SET_W-1:0] set_index,
                             input logic [WAY_W-1:0] way,
                             output logic [VICTIM_W-1:0] victim);
        int               slot;
        int               i;
        logic [WAY_W-1:0] moved;
        slot = LRU_WAYS;
        if (kind == KIND_TOUCH || kind == KIND_INVALIDATE) begin
            for (i = 0; i < LRU_WAYS; i++) begin
                if (slot == LRU_WAYS && lru_order[set_index][i] == way) begin
                    slot = i;
                end
            end
        end
        if (slot < LRU_WAYS) begin
            moved = lru_order[set_index][slot];
            if (kind == KIND_TOUCH) begin
                for (i = slot; i < LRU_WAYS - 1; i++) begin
                    lru_order[set_index][i] = lru_order[set_index][i + 1];
                end
                lru_order[set_index][LRU_WAYS - 1] = moved;
            end else begin
                for (i = slot; i > 0; i--) begin
                    lru_order[set_index][i] = lru_order[set_index][i - 1];
                end
                lru_order[set_index][0] = moved;
            end
        end
        victim = lru_order[set_index][0];
    endtask

    function automatic void add_request(input logic [KIND_W-1:0] kind,
                                        input logic [SET_W-1:0] set_index,
                                        input logic [WAY_W-1:0] way,
                                        input bit drain);
        t_lru_request req;
        req.kind      = kind;
        req.set_index = set_index;
        req.way       = way;
        req.drain     = drain;
        request_queue = {request_queue, req};
    endfunction

    // Stimulus, reset and the end of the run.
    initial begin
        int               n;
        int               pick;
        int               total_requests;
        logic [KIND_W-1:0] kind;
        logic [SET_W-1:0]  set_index;
        logic [SET_W-1:0]  hot_sets [4];

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = '0;
        i_set_index = '0;
        i_way       = '0;
        i_out_stall = 1'b0;

        // Reset leaves every set in the identity order.
        for (int s = 0; s < LRU_SETS; s++) begin
            for (int p = 0; p < LRU_WAYS; p++) begin
                lru_order[s][p] = p[WAY_W-1:0];
            end
        end

        // Directed opening. It runs back to back, so requests to one set
        // follow each other closely and exercise the write-back bypass.
        add_request(KIND_QUERY,      6'd0,  2'd0, 1'b0);
        add_request(KIND_SPARE,      6'd63, 2'd3, 1'b0);
        add_request(KIND_TOUCH,      6'd0,  2'd0, 1'b0);
        // Touching the way that is already most recent changes nothing.
        add_request(KIND_TOUCH,      6'd0,  2'd0, 1'b0);
        add_request(KIND_TOUCH,      6'd0,  2'd1, 1'b0);
        add_request(KIND_INVALIDATE, 6'd0,  2'd1, 1'b0);
        // Invalidating the way that is already least recent changes nothing.
        add_request(KIND_INVALIDATE, 6'd0,  2'd1, 1'b0);
        add_request(KIND_TOUCH,      6'd63, 2'd3, 1'b0);
        add_request(KIND_INVALIDATE, 6'd63, 2'd3, 1'b0);
        // A query carries a way number that must be ignored.
        add_request(KIND_QUERY,      6'd63, 2'd0, 1'b0);
        add_request(KIND_TOUCH,      6'd63, 2'd3, 1'b0);
        add_request(KIND_TOUCH,      6'd42, 2'd2, 1'b0);
        add_request(KIND_TOUCH,      6'd42, 2'd1, 1'b0);
        add_request(KIND_TOUCH,      6'd42, 2'd0, 1'b0);
        add_request(KIND_INVALIDATE, 6'd42, 2'd0, 1'b0);
        // The spare kind code must not reorder, even with a way given.
        add_request(KIND_SPARE,      6'd42, 2'd2, 1'b0);
        add_request(KIND_QUERY,      6'd42, 2'd3, 1'b0);
        // This one waits until the pipeline has emptied.
        add_request(KIND_TOUCH,      6'd21, 2'd0, 1'b1);
        add_request(KIND_TOUCH,      6'd1,  2'd3, 1'b0);
        add_request(KIND_INVALIDATE, 6'd62, 2'd2, 1'b0);
        add_request(KIND_QUERY,      6'd0,  2'd2, 1'b0);

        // Random part. Most requests land on a handful of hot sets so that
        // their orders are stirred deeply and repeated accesses hit the
        // bypass; the rest are spread over all sets.
        hot_sets[0] = 6'd0;
        hot_sets[1] = 6'd21;
        hot_sets[2] = 6'd42;
        hot_sets[3] = 6'd63;
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 10) begin
                kind = KIND_TOUCH;
            end else if (pick < 15) begin
                kind = KIND_INVALIDATE;
            end else if (pick < 18) begin
                kind = KIND_QUERY;
            end else begin
                kind = KIND_SPARE;
            end
            if ($urandom_range(0, 9) < 6) begin
                set_index = hot_sets[$urandom_range(0, 3)];
            end else begin
                set_index = SET_W'($urandom_range(0, LRU_SETS - 1));
            end
            add_request(kind, set_index, WAY_W'($urandom_range(0, LRU_WAYS - 1)),
                        (n % 150) == 149);
        end
        total_requests = request_queue.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every result; the watchdog ends the run if they stop.
        while (result_count < total_requests) begin
            @(posedge i_clk);
        end
        // Keep clocking to catch any stray result after the last one.
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0 && victim_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Request driver. A new request is presented only once the previous one
    // has been taken, after the gap drawn for it. Whilst idle the payload
    // wanders randomly, so the block must not look at it without a valid.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                lru_apply(i_kind, i_set_index, i_way, victim_next);
                victim_expect = {victim_expect, victim_next};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0 || request_queue.size() == 0 ||
                    (request_queue[0].drain && victim_expect.size() != 0)) begin
                    if (send_gap > 0) begin
                        send_gap--;
                    end
                    i_in_valid  <= 1'b0;
                    i_kind      <= KIND_W'($urandom);
                    i_set_index <= SET_W'($urandom);
                    i_way       <= WAY_W'($urandom);
                end else begin
                    next_request = request_queue.pop_front();
                    i_in_valid  <= 1'b1;
                    i_kind      <= next_request.kind;
                    i_set_index <= next_request.set_index;
                    i_way       <= next_request.way;
                    issued_count++;
                    // Alternate between back-to-back spells and gappy ones.
                    if (issued_count % 40 == 0) begin
                        send_burst = 1'($urandom_range(0, 1));
                    end
                    send_gap = send_burst ? 0 : $urandom_range(0, 9);
                end
            end
        end
    end

    // Result monitor and receiver stall. Each result is checked against the
    // oldest expectation; the stall for the next result is drawn as this one
    // is taken. Twice in the run the receiver holds off for a long stretch so
    // that the block fills and pushes back on requests.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (victim_expect.size() == 0) begin
                    $display("%0t: victim_way expected none, actual %0d",
                             $time, o_victim_way);
                    mismatch_count++;
                end else begin
                    victim_want = victim_expect.pop_front();
                    if (o_victim_way !== victim_want) begin
                        $display("%0t: victim_way expected %0d, actual %0d",
                                 $time, victim_want, o_victim_way);
                        mismatch_count++;
                    end
                end
                if (result_count % 50 == 0) begin
                    recv_burst = 1'($urandom_range(0, 1));
                end
                if (result_count == HOLD_AT_FIRST || result_count == HOLD_AT_LATER) begin
                    recv_hold = LONG_HOLD;
                end else begin
                    recv_hold = recv_burst ? 0 : $urandom_range(0, 9);
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: counts cycles in which neither channel completes a handshake.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

endmodule
